### rtl/core/ipdq_pkg.sv
// types, character constants and octet arithmetic for the dotted-quad recogniser
`timescale 1ns / 1ps
`default_nettype none

package ipdq_pkg;

    // character codes
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    // octet accumulator saturation value
    localparam logic [8:0] OCTET_CAP = 9'd256;

    // index of the fourth field
    localparam logic [1:0] LAST_FIELD = 2'd3;

    typedef logic [8:0] octet_t;
    typedef logic [1:0] field_idx_t;

    // one result item
    typedef struct packed {
        logic        is_address;
        logic [31:0] address;
    } result_t;

    // accumulate one decimal digit, saturating at the cap
    function automatic octet_t next_octet(input octet_t cur, input logic [7:0] ch);
        logic [11:0] prod;
        logic [11:0] digit;
        logic [11:0] sum;
        begin
            prod  = {cur, 3'b000} + {2'b00, cur, 1'b0};
            digit = {4'h0, ch - CH_ZERO};
            sum   = prod + digit;
            next_octet = (sum > {3'b000, OCTET_CAP}) ? OCTET_CAP : sum[8:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/ipdq_scan.sv
// scan state for one string and the verdict formed on its terminator
`timescale 1ns / 1ps
`default_nettype none

module ipdq_scan
    import ipdq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] char_code,
    output result_t         result
);

    field_idx_t field_idx_reg, field_idx_next;
    logic       started_reg, started_next;
    logic       stopped_reg, stopped_next;
    logic       rejected_reg, rejected_next;
    octet_t     octet_reg [4];
    octet_t     octet_next [4];

    logic is_dot;
    logic is_digit;
    logic ok;

    assign is_dot   = (char_code == CH_DOT);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

    // next scan state
    always_comb
    begin
        field_idx_next = field_idx_reg;
        started_next   = started_reg;
        stopped_next   = stopped_reg;
        rejected_next  = rejected_reg;
        for (int i = 0; i < 4; i++)
        begin
            octet_next[i] = octet_reg[i];
        end
        if (char_code == CH_NUL)
        begin
            field_idx_next = '0;
            started_next   = 1'b0;
            stopped_next   = 1'b0;
            rejected_next  = 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                octet_next[i] = '0;
            end
        end
        else if (!stopped_reg && !rejected_reg)
        begin
            if (is_dot)
            begin
                if (field_idx_reg == LAST_FIELD)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    field_idx_next = field_idx_reg + 2'd1;
                    started_next   = 1'b0;
                end
            end
            else if (is_digit)
            begin
                octet_next[field_idx_reg] = next_octet(octet_reg[field_idx_reg], char_code);
                started_next = 1'b1;
            end
            else
            begin
                started_next = 1'b1;
                stopped_next = 1'b1;
            end
        end
    end

    // verdict on the current state
    always_comb
    begin
        ok = !rejected_reg && (field_idx_reg == LAST_FIELD) && started_reg
             && (octet_reg[0] != 9'd0) && !octet_reg[0][8]
             && !octet_reg[1][8] && !octet_reg[2][8] && !octet_reg[3][8];
        result.is_address = ok;
        result.address    = ok ? {octet_reg[0][7:0], octet_reg[1][7:0],
                                  octet_reg[2][7:0], octet_reg[3][7:0]} : 32'd0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_idx_reg <= '0;
            started_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
            rejected_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                octet_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            field_idx_reg <= field_idx_next;
            started_reg   <= started_next;
            stopped_reg   <= stopped_next;
            rejected_reg  <= rejected_next;
            for (int i = 0; i < 4; i++)
            begin
                octet_reg[i] <= octet_next[i];
            end
        end
    end

    // a fifth field can only be opened from the fourth
    assert property (@(posedge clk) disable iff (!rst_n)
        rejected_reg |-> (field_idx_reg == LAST_FIELD))
        else $error("rejected outside the last field");

    // accumulators stay within the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        (octet_reg[0] <= OCTET_CAP) && (octet_reg[1] <= OCTET_CAP)
        && (octet_reg[2] <= OCTET_CAP) && (octet_reg[3] <= OCTET_CAP))
        else $error("octet accumulator above cap");

    // a stopping character always marks the field present
    assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> started_reg)
        else $error("scan stopped without field present");

endmodule

`default_nettype wire

### rtl/core/ipdq_out_reg.sv
// result register holding one verdict until the master side takes it
`timescale 1ns / 1ps
`default_nettype none

module ipdq_out_reg
    import ipdq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire result_t     result,
    output logic             ready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    output logic [0:0]       m_tuser
);

    logic    valid_reg;
    result_t data_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.address;
    assign m_tuser  = data_reg.is_address;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            data_reg <= result;
        end
    end

    // a load never lands on a waiting request
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ready)
        else $error("result loaded while output stalled");

    // a rejected string carries a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !data_reg.is_address) |-> (data_reg.address == 32'd0))
        else $error("address not zero on rejected string");

    // a waiting request keeps its verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

### rtl/core/ipv4_dotted_quad_recognizer.sv
// top level: input register, scan stage and result register
// path: an accepted terminator moves from the input register into the result register, which loads the scan verdict
// throughput: one character per cycle; the scan state update is a single stage
// stalls only when a terminator meets a result not yet taken
// reset: rst_n asynchronous active low clears scan state and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module ipv4_dotted_quad_recognizer
    import ipdq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_code
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // address
    output logic [0:0]       m_tuser    // is_address
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       out_ready;
    logic       advance;
    logic       load;
    result_t    result;

    // the registered character moves on unless a terminator meets a full output
    assign advance  = in_valid_reg && ((in_char_reg != CH_NUL) || out_ready);
    assign load     = advance && (in_char_reg == CH_NUL);
    assign s_tready = !in_valid_reg || advance;

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
        end
    end

    // scan stage
    ipdq_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (in_char_reg),
        .result    (result)
    );

    // result register
    ipdq_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### tb/sv/ipv4_dotted_quad_recognizer_tb.sv
// self-checking testbench for the dotted-quad recogniser: string stimulus and verdict scoreboard
`timescale 1ns / 1ps

module ipv4_dotted_quad_recognizer_tb;
    import ipdq_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;
    localparam int ITEMS_TOTAL  = 1250;

    // running copy of the scan and the queue of verdicts still owed
    class quad_scoreboard;
        field_idx_t  field_idx;
        logic        started;
        logic        stopped;
        logic        rejected;
        octet_t      octets [4];
        result_t     verdict_q [$];
        int unsigned errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            field_idx = '0;
            started   = 1'b0;
            stopped   = 1'b0;
            rejected  = 1'b0;
            foreach (octets[i]) octets[i] = '0;
        endfunction

        // note one accepted character request
        function void absorb_char(logic [7:0] ch);
            int      acc;
            logic    ok;
            result_t verdict;
            if (ch == CH_NUL) begin
                ok = !rejected && field_idx == LAST_FIELD && started
                     && octets[0] >= 9'd1 && octets[0] <= 9'd255
                     && octets[1] <= 9'd255 && octets[2] <= 9'd255
                     && octets[3] <= 9'd255;
                verdict.is_address = ok;
                verdict.address    = ok ? {octets[0][7:0], octets[1][7:0],
                                           octets[2][7:0], octets[3][7:0]} : 32'd0;
                verdict_q.push_back(verdict);
                restart();
            end
            else if (!stopped && !rejected) begin
                if (ch == CH_DOT) begin
                    // a dot in the fourth field opens a fifth one
                    if (field_idx == LAST_FIELD)
                        rejected = 1'b1;
                    else
                    begin
                        field_idx = field_idx + 2'd1;
                        started   = 1'b0;
                    end
                end
                else if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    acc = int'(octets[field_idx]) * 10 + int'(ch - CH_ZERO);
                    octets[field_idx] = (acc > int'(OCTET_CAP)) ? OCTET_CAP : octet_t'(acc);
                    started = 1'b1;
                end
                else
                begin
                    started = 1'b1;
                    stopped = 1'b1;
                end
            end
        endfunction

        // compare one accepted verdict with the oldest one owed
        function void compare_verdict(logic is_addr, logic [31:0] addr);
            result_t want;
            if (verdict_q.size() == 0) begin
                $error("unexpected verdict: is_address %0d address %08h", is_addr, addr);
                errors++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (is_addr !== want.is_address) begin
                    $error("is_address: expected %0d, got %0d", want.is_address, is_addr);
                    errors++;
                end
                if (addr !== want.address) begin
                    $error("address: expected %08h, got %08h", want.address, addr);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return verdict_q.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    int          tx_idle_pct = 32;
    int          rx_idle_pct = 85;
    int          items_sent  = 0;
    int          quiet_cycles = 0;
    logic [7:0]  text_q [$];
    quad_scoreboard sb;

    ipv4_dotted_quad_recognizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // char_code
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // address
        .m_tuser  (m_tuser)     // is_address
    );

    always #HALF_PERIOD clk = ~clk;

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // result monitor
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.compare_verdict(m_tuser[0], m_tdata);

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ipv4_dotted_quad_recognizer_tb NOT OK");
                $finish;
            end
        end

    // non-zero byte, biased towards digits and dots
    function automatic logic [7:0] any_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return CH_ZERO + 8'($urandom_range(0, 9));
        else if (pick < 60)
            return CH_DOT;
        else
            return 8'($urandom_range(1, 255));
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // one decimal field, mostly in range
    task automatic push_field();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 58)
            push_str($sformatf("%0d", $urandom_range(0, 255)));
        else if (pick < 68)
            push_str($sformatf("%0d", $urandom_range(256, 999)));
        else if (pick < 76)
            ;   // empty field
        else if (pick < 86)
            push_str($sformatf("0%0d", $urandom_range(0, 255)));
        else if (pick < 93)
            push_str(($urandom_range(0, 1) != 0) ? "255" : "0");
        else
            push_str($sformatf("%0d", $urandom_range(1000, 999999)));
    endtask

    // random string: mostly dotted quads, some broken, some noise
    task automatic make_string();
        int mode;
        int fields;
        int pick;
        text_q.delete();
        mode = $urandom_range(0, 99);
        if (mode < 15) begin
            repeat ($urandom_range(0, 10)) text_q.push_back(any_char());
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                fields = 4;
            else if (pick < 88)
                fields = $urandom_range(1, 3);
            else
                fields = 5;
            for (int f = 0; f < fields; f++) begin
                if (f > 0)
                    text_q.push_back(CH_DOT);
                push_field();
            end
            if (mode < 30 && text_q.size() > 0)
                text_q[$urandom_range(0, text_q.size() - 1)] = any_char();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) text_q.push_back(any_char());
        end
        text_q.push_back(CH_NUL);
    endtask

    // present one character request and wait for it to be taken
    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do @(posedge clk); while (!s_tready);
        sb.absorb_char(ch);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_char(text_q[i]);
    endtask

    task automatic send_directed(input string s);
        text_q.delete();
        push_str(s);
        text_q.push_back(CH_NUL);
        send_text();
    endtask

    // main sequence
    initial begin
        sb = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes of the octets, valid
        send_directed("255.0.99.1");
        // zero first octet and empty fields
        send_directed("0...");
        // empty string
        send_directed("");
        // fifth field
        send_directed("1.2.3.4.");
        // stop character with the top bit set in the fourth field
        text_q.delete();
        push_str("9.8.7.");
        text_q.push_back(8'hFF);
        text_q.push_back(CH_DOT);
        text_q.push_back(CH_NUL);
        send_text();
        // saturating octet
        send_directed("1.2.3.9999");

        // random strings in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 85 : 0;
            rx_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 32 : 0;
            while (items_sent < (ITEMS_TOTAL * (phase + 1)) / 3) begin
                make_string();
                send_text();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("ipv4_dotted_quad_recognizer_tb OK");
        else
            $display("ipv4_dotted_quad_recognizer_tb NOT OK");
        $finish;
    end

endmodule
